FILE: design/mm4_pkg.sv
`timescale 1ns / 1ps

package mm4_pkg;

  // Element format is fixed by the interface: signed 32-bit fixed point
  localparam int unsigned DATA_W = 32;

  // Defaults for the top-level parameters
  localparam int unsigned DIM_DEF       = 4;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Command codes on op_i
  typedef enum logic [1:0] {
    OP_LOAD_LEFT  = 2'd0,
    OP_LOAD_RIGHT = 2'd1,
    OP_MULTIPLY   = 2'd2
  } op_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_e;

endpackage

FILE: design/mm4_cell.sv
`timescale 1ns / 1ps

// One link of the dot-product chain. Cell k holds column k of the left
// matrix and row k of the right matrix, multiplies the pair picked by the
// passing beat's (row, col) and adds the product to the running sum.
module mm4_cell
  import mm4_pkg::*;
#(
  parameter int unsigned DIM       = DIM_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned CELL_IDX  = 0,
  localparam int unsigned IDX_W    = $clog2(DIM),
  localparam int unsigned ACC_W    = 2 * DATA_W + $clog2(DIM)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // element writes
  input  logic                    wr_left_i,
  input  logic                    wr_right_i,
  input  logic [IDX_W-1:0]        wr_idx_i,
  input  logic [DATA_W-1:0]       wr_data_i,
  // beat from the previous cell
  input  logic                    vld_i,
  input  logic                    last_i,
  input  logic [IDX_W-1:0]        row_i,
  input  logic [IDX_W-1:0]        col_i,
  input  logic signed [ACC_W-1:0] sum_i,
  // beat to the next cell
  output logic                    vld_o,
  output logic                    last_o,
  output logic [IDX_W-1:0]        row_o,
  output logic [IDX_W-1:0]        col_o,
  output logic signed [ACC_W-1:0] sum_o
);

  localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

  logic [DATA_W-1:0] lcol_q [DIM];
  logic [DATA_W-1:0] rrow_q [DIM];

  logic signed [DATA_W-1:0]   opa, opb;
  logic signed [2*DATA_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0]    sum_a_q, sum_d, sum_q;
  logic                       a_vld_q, a_last_q, b_vld_q, b_last_q;
  logic [IDX_W-1:0]           a_row_q, a_col_q, b_row_q, b_col_q;

  // local slices of both matrices, identity after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIM; i++) begin
        lcol_q[i] <= (i == CELL_IDX) ? ONE : '0;
        rrow_q[i] <= (i == CELL_IDX) ? ONE : '0;
      end
    end else begin
      if (wr_left_i) begin
        lcol_q[wr_idx_i] <= wr_data_i;
      end
      if (wr_right_i) begin
        rrow_q[wr_idx_i] <= wr_data_i;
      end
    end
  end

  // operand select and multiply
  assign opa    = $signed(lcol_q[row_i]);
  assign opb    = $signed(rrow_q[col_i]);
  assign prod_d = opa * opb;

  // accumulate
  assign sum_d = sum_a_q + ACC_W'($signed(prod_q));

  // control of both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      a_vld_q <= vld_i;
      b_vld_q <= a_vld_q;
    end
  end

  // payload of both stages
  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    sum_a_q  <= sum_i;
    a_last_q <= last_i;
    a_row_q  <= row_i;
    a_col_q  <= col_i;
    sum_q    <= sum_d;
    b_last_q <= a_last_q;
    b_row_q  <= a_row_q;
    b_col_q  <= a_col_q;
  end

  assign vld_o  = b_vld_q;
  assign last_o = b_last_q;
  assign row_o  = b_row_q;
  assign col_o  = b_col_q;
  assign sum_o  = sum_q;

endmodule

FILE: design/matrix_multiply_4x4.sv
`timescale 1ns / 1ps

// Fixed-point DIM x DIM matrix multiplier holding a left and a right matrix.
// Commands: a beat is taken when start_i is high and busy_o is low.
//   op_i = load left / load right writes element (row_i, col_i) with value_i;
//   it leaves busy_o low, so loads can arrive every cycle.
//   op_i = multiply streams the DIM*DIM elements of left * right, row-major,
//   one per cycle with out_valid_o high, last_o on the final one.
//   Unused op codes and out-of-range indices are dropped.
// The first product element passes two stages per cell of the chain plus
//   the output register before it reaches the outputs; busy_o stays high
//   from the accepted multiply until the last beat has left the cell chain.
// Each element is the exact sum of DIM 64-bit products, floor-shifted by
//   FRAC_BITS and saturated to 32 bits; saturated_o flags clipping.
// Reset: both matrices return to identity, the sequencer goes idle.
// The receiver cannot stall: each result is present for one cycle only.
module matrix_multiply_4x4
  import mm4_pkg::*;
#(
  parameter int unsigned DIM       = DIM_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  localparam int unsigned IDX_W    = $clog2(DIM)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [1:0]               op_i,
  input  logic [IDX_W-1:0]         row_i,
  input  logic [IDX_W-1:0]         col_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  output logic [IDX_W-1:0]         out_row_o,
  output logic [IDX_W-1:0]         out_col_o,
  output logic signed [DATA_W-1:0] product_o,
  output logic                     saturated_o,
  output logic                     last_o
);

  localparam int unsigned ACC_W = 2 * DATA_W + $clog2(DIM);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DIM - 1);

  state_e state_q, state_d;
  logic   accept, in_range, load_left, load_right, go_mul;
  logic [IDX_W-1:0] r_q, r_d, c_q, c_d;
  logic   issue_vld, issue_last;

  // chain links, entry 0 feeds the first cell
  logic                    ch_vld  [DIM+1];
  logic                    ch_last [DIM+1];
  logic [IDX_W-1:0]        ch_row  [DIM+1];
  logic [IDX_W-1:0]        ch_col  [DIM+1];
  logic signed [ACC_W-1:0] ch_sum  [DIM+1];

  // command decode
  assign accept   = start_i && !busy_o;
  assign in_range = ({1'b0, row_i} < (IDX_W+1)'(DIM)) &&
                    ({1'b0, col_i} < (IDX_W+1)'(DIM));

  always_comb begin
    load_left  = 1'b0;
    load_right = 1'b0;
    go_mul     = 1'b0;
    unique case (op_i)
      OP_LOAD_LEFT:  load_left  = accept && in_range;
      OP_LOAD_RIGHT: load_right = accept && in_range;
      OP_MULTIPLY:   go_mul     = accept;
      default: ;
    endcase
  end

  // sequencer: issue one (row, col) beat per cycle, then wait for the drain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      r_q     <= '0;
      c_q     <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    r_d        = r_q;
    c_d        = c_q;
    issue_vld  = 1'b0;
    issue_last = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        r_d = '0;
        c_d = '0;
        if (go_mul) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        issue_vld  = 1'b1;
        issue_last = (r_q == IDX_MAX) && (c_q == IDX_MAX);
        if (c_q == IDX_MAX) begin
          c_d = '0;
          r_d = r_q + IDX_W'(1);
        end else begin
          c_d = c_q + IDX_W'(1);
        end
        if (issue_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (ch_vld[DIM] && ch_last[DIM]) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  // chain head
  assign ch_vld[0]  = issue_vld;
  assign ch_last[0] = issue_last;
  assign ch_row[0]  = r_q;
  assign ch_col[0]  = c_q;
  assign ch_sum[0]  = '0;

  // cell k holds left column k and right row k
  for (genvar k = 0; k < DIM; k++) begin : g_cell
    logic wr_l, wr_r;
    logic [IDX_W-1:0] wr_idx;

    assign wr_l   = load_left && (col_i == IDX_W'(k));
    assign wr_r   = load_right && (row_i == IDX_W'(k));
    assign wr_idx = wr_l ? row_i : col_i;

    mm4_cell #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS),
      .CELL_IDX  (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_left_i  (wr_l),
      .wr_right_i (wr_r),
      .wr_idx_i   (wr_idx),
      .wr_data_i  (value_i),
      .vld_i      (ch_vld[k]),
      .last_i     (ch_last[k]),
      .row_i      (ch_row[k]),
      .col_i      (ch_col[k]),
      .sum_i      (ch_sum[k]),
      .vld_o      (ch_vld[k+1]),
      .last_o     (ch_last[k+1]),
      .row_o      (ch_row[k+1]),
      .col_o      (ch_col[k+1]),
      .sum_o      (ch_sum[k+1])
    );
  end

  // floor shift and saturate
  logic signed [ACC_W-1:0]  shifted;
  logic                     sat_d;
  logic signed [DATA_W-1:0] res_d;

  assign shifted = ch_sum[DIM] >>> FRAC_BITS;

  always_comb begin
    sat_d = (shifted[ACC_W-1:DATA_W-1] != '0) && (shifted[ACC_W-1:DATA_W-1] != '1);
    if (!sat_d) begin
      res_d = shifted[DATA_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      res_d = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res_d = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else begin
      out_valid_o <= ch_vld[DIM];
    end
  end

  always_ff @(posedge clk_i) begin
    out_row_o   <= ch_row[DIM];
    out_col_o   <= ch_col[DIM];
    product_o   <= res_d;
    saturated_o <= sat_d;
    last_o      <= ch_last[DIM];
  end

endmodule
